// ----- rtl/core/crc_checked_packet_receiver_assert.svh -----
`ifndef CRC_CHECKED_PACKET_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_PACKET_RECEIVER_ASSERT_SVH

// Checks a condition at every clock edge outside of reset.
`define CCPR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define CCPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CCPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ccpr_pkg.sv -----
package ccpr_pkg;

	localparam int FRAME_LEN   = 8;
	localparam int CRC_BYTES   = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int FILL_W      = $clog2(FRAME_LEN + 1);
	localparam int IDX_W       = $clog2(FRAME_LEN);

	localparam logic [7:0]        SYNC_BYTE = 8'h11;
	localparam logic [15:0]       CRC_POLY  = 16'h1021;
	localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LEN);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0]  CRC_LAST  = IDX_W'(CRC_BYTES - 1);

	typedef struct packed {
		logic [7:0] data;
		logic       is_sync;
	} item_t;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_CRC,
		ST_CHECK,
		ST_EMIT,
		ST_SEARCH
	} back_state_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/ccpr_front.sv -----
module ccpr_front (
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     rx_byte,
	input  logic           sending,
	input  logic           q_full,
	output logic           push,
	output ccpr_pkg::item_t push_item
);

	// Bytes seen while the local transmitter is active are consumed and discarded.
	assign in_stall          = q_full;
	assign push              = in_valid && !q_full && !sending;
	assign push_item.data    = rx_byte;
	assign push_item.is_sync = (rx_byte == ccpr_pkg::SYNC_BYTE);

endmodule

// ----- rtl/core/ccpr_queue.sv -----
`include "crc_checked_packet_receiver_assert.svh"

module ccpr_queue #(
	parameter int DEPTH = ccpr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccpr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output ccpr_pkg::item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	ccpr_pkg::item_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`CCPR_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "queue count out of range")
	`CCPR_ASSERT_IMPLY(a_no_overflow, push, !full, "push into a full queue")
	`CCPR_ASSERT_IMPLY(a_no_underflow, pop, pop_valid, "pop from an empty queue")

endmodule

// ----- rtl/core/ccpr_back.sv -----
`include "crc_checked_packet_receiver_assert.svh"

module ccpr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            own_node_we,
	input  logic [7:0]      own_node,
	input  logic            q_valid,
	input  ccpr_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            kind,
	output logic [7:0]      node,
	output logic [7:0]      frame_type,
	output logic [7:0]      port,
	output logic [15:0]     payload
);

	localparam int CRC_HI = ccpr_pkg::FRAME_LEN - 2;
	localparam int CRC_LO = ccpr_pkg::FRAME_LEN - 1;

	ccpr_pkg::back_state_t state_q;
	ccpr_pkg::back_state_t state_d;

	logic [7:0]                    buf_q [ccpr_pkg::FRAME_LEN];
	logic [ccpr_pkg::FILL_W-1:0]   fill_q;
	logic [ccpr_pkg::IDX_W-1:0]    idx_q;
	logic [15:0]                   crc_q;
	logic                          err_q;
	logic [7:0]                    own_node_q;
	logic                          out_valid_q;

	logic take_byte;
	logic crc_ok;
	logic node_ok;
	logic out_free;
	logic out_load;
	logic search_done;

	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		crc_ok      = ({buf_q[CRC_HI], buf_q[CRC_LO]} == crc_q);
		node_ok     = (buf_q[1] == 8'h00) || (buf_q[1] == own_node_q);
		search_done = (fill_q == ccpr_pkg::FILL_W'(1)) || (buf_q[1] == ccpr_pkg::SYNC_BYTE);
		q_pop       = (state_q == ccpr_pkg::ST_COLLECT) && q_valid;
		take_byte   = q_pop && ((fill_q != '0) || q_item.is_sync);
		out_load    = (state_q == ccpr_pkg::ST_EMIT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccpr_pkg::ST_COLLECT: begin
				if (take_byte && (fill_q == ccpr_pkg::FILL_LAST)) begin
					state_d = ccpr_pkg::ST_CRC;
				end
			end
			ccpr_pkg::ST_CRC: begin
				if (idx_q == ccpr_pkg::CRC_LAST) begin
					state_d = ccpr_pkg::ST_CHECK;
				end
			end
			ccpr_pkg::ST_CHECK: begin
				if (!crc_ok || node_ok) begin
					state_d = ccpr_pkg::ST_EMIT;
				end else begin
					state_d = ccpr_pkg::ST_COLLECT;
				end
			end
			ccpr_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = err_q ? ccpr_pkg::ST_SEARCH : ccpr_pkg::ST_COLLECT;
				end
			end
			ccpr_pkg::ST_SEARCH: begin
				if (search_done) begin
					state_d = ccpr_pkg::ST_COLLECT;
				end
			end
			default: state_d = ccpr_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ccpr_pkg::ST_COLLECT;
			fill_q     <= '0;
			idx_q      <= '0;
			crc_q      <= ccpr_pkg::CRC_INIT;
			err_q      <= 1'b0;
			own_node_q <= 8'h00;
		end else begin
			state_q <= state_d;
			if (own_node_we) begin
				own_node_q <= own_node;
			end
			unique case (state_q)
				ccpr_pkg::ST_COLLECT: begin
					if (take_byte) begin
						fill_q <= fill_q + ccpr_pkg::FILL_W'(1);
						idx_q  <= '0;
						crc_q  <= ccpr_pkg::CRC_INIT;
					end
				end
				ccpr_pkg::ST_CRC: begin
					crc_q <= ccpr_pkg::crc_update(crc_q, buf_q[idx_q]);
					idx_q <= idx_q + ccpr_pkg::IDX_W'(1);
				end
				ccpr_pkg::ST_CHECK: begin
					err_q <= !crc_ok;
					if (crc_ok) begin
						fill_q <= '0;
					end
				end
				ccpr_pkg::ST_EMIT: begin
				end
				ccpr_pkg::ST_SEARCH: begin
					fill_q <= fill_q - ccpr_pkg::FILL_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// During the resync search the buffer moves down one place per cycle.
	always_ff @(posedge clk) begin
		if (take_byte) begin
			buf_q[fill_q[ccpr_pkg::IDX_W-1:0]] <= q_item.data;
		end else if (state_q == ccpr_pkg::ST_SEARCH) begin
			for (int k = 0; k < ccpr_pkg::FRAME_LEN - 1; k++) begin
				buf_q[k] <= buf_q[k + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind       <= err_q;
			node       <= err_q ? 8'h00 : buf_q[1];
			frame_type <= err_q ? 8'h00 : buf_q[2];
			port       <= err_q ? 8'h00 : buf_q[3];
			payload    <= err_q ? 16'h0000 : {buf_q[5], buf_q[4]};
		end
	end

	assign out_valid = out_valid_q;

	`CCPR_ASSERT_ALWAYS(a_fill_range, fill_q <= ccpr_pkg::FILL_FULL, "fill count above frame length")
	`CCPR_ASSERT_IMPLY(a_crc_full, state_q == ccpr_pkg::ST_CRC, fill_q == ccpr_pkg::FILL_FULL, "CRC pass without a full frame")
	`CCPR_ASSERT_IMPLY(a_pop_collect, q_pop, state_q == ccpr_pkg::ST_COLLECT, "queue popped while busy")
	`CCPR_ASSERT_NEXT(a_search_exit, (state_q == ccpr_pkg::ST_SEARCH) && (state_d != ccpr_pkg::ST_SEARCH), (state_q == ccpr_pkg::ST_COLLECT) && (fill_q < ccpr_pkg::FILL_FULL), "resync left a full buffer")

endmodule

// ----- rtl/core/crc_checked_packet_receiver.sv -----
// Receives serial bytes on the input channel (in_valid, in_stall, rx_byte, sending) and
// assembles 8-byte frames that start with the sync byte 0x11 and end in a CRC-16.
// A byte taken while sending is high is discarded, as is a non-sync byte with no frame open.
// The output (out_valid, out_stall) carries at most one transaction per checked frame:
// kind 0 with the decoded fields for a good frame addressed to node 0 or to own_node,
// kind 1 with zero fields on a CRC mismatch. Good frames for other nodes give nothing.
// The user must see that own_node is written with own_node_we only while the block is
// idle; the block does not enforce this. Bytes pass a small queue, so the input takes
// one byte per cycle while it has room. While collecting, the frame engine takes one
// byte per cycle; after the last byte of a frame it runs the CRC over the first six
// bytes (one byte per cycle), then the compare, then loads the output register.
// After a CRC failure the error result is emitted, then a resync search shifts the
// buffer down until a sync byte reaches its head or one byte is left.
// A stalled result holds in the output register; the engine then waits, the queue fills
// and in_stall rises. Reset clears the queue, the frame buffer count, the output valid
// and own_node.
module crc_checked_packet_receiver #(
	parameter int QUEUE_DEPTH = ccpr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        own_node_we,
	input  logic [7:0]  own_node,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        sending,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  node,
	output logic [7:0]  frame_type,
	output logic [7:0]  port,
	output logic [15:0] payload
);

	logic            push;
	ccpr_pkg::item_t push_item;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	ccpr_pkg::item_t q_item;

	ccpr_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.sending   (sending),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	ccpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	ccpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_node_we (own_node_we),
		.own_node    (own_node),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.node        (node),
		.frame_type  (frame_type),
		.port        (port),
		.payload     (payload)
	);

endmodule
